// ----- sv/hbc_pkg.sv -----
`default_nettype none
package hbc_pkg;

    typedef enum logic [1:0] {
        OP_H2S = 2'd0,
        OP_S2H = 2'd1,
        OP_B2S = 2'd2,
        OP_S2B = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result;
    } out_item_t;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  ex;
        logic [9:0]  frac;
        logic [3:0]  n;
        logic        found;
        logic [10:0] sh;
        logic [31:0] r;
        sign = {h[15], 31'd0};
        ex = h[14:10];
        frac = h[9:0];
        n = 4'd0;
        found = 1'b0;
        for (int i = 9; i >= 0; i--)
        begin
            if (!found && frac[i])
            begin
                found = 1'b1;
                n = 4'(10 - i);
            end
        end
        sh = {1'b0, frac} << n;
        if (ex == 5'h1F)
            r = sign | 32'h7F80_0000 | {9'd0, frac, 13'd0};
        else if (ex == 5'd0)
        begin
            if (frac == 10'd0)
                r = sign;
            else
                r = sign | {1'b0, 8'(8'd113 - {4'd0, n}), sh[9:0], 13'd0};
        end
        else
            r = sign | {1'b0, 8'({3'd0, ex} + 8'd112), frac, 13'd0};
        return r;
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        logic [15:0] sign;
        logic [7:0]  e;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [23:0] t;
        logic [23:0] fr;
        logic [4:0]  he;
        logic [15:0] r;
        sign = {f[31], 15'd0};
        e = f[30:23];
        m = {1'b1, f[22:0]};
        if (e <= 8'd113)
            sh = (e < 8'd89) ? 5'd24 : 5'(8'd113 - e);
        else
            sh = 5'd0;
        t = (m >> sh) + 24'h1000;
        fr = {1'b0, f[22:0]} + 24'h1000;
        he = 5'(e - 8'd112);
        if (e >= 8'd143)
            r = sign | 16'h7C00;
        else if (e <= 8'd112)
            r = sign | {5'd0, t[23:13]};
        else if (fr[23])
            r = sign | {1'b0, 5'(he + 5'd1), 10'd0};
        else
            r = sign | {1'b0, he, fr[22:13]};
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/hbc_stream_if.sv -----
`default_nettype none
interface hbc_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/hbc_convert.sv -----
`default_nettype none
module hbc_convert (
    input  wire hbc_pkg::in_item_t  item,
    output hbc_pkg::out_item_t      res
);
    logic [31:0] s2b;

    always_comb
    begin
        s2b = item.value + 32'h7FFF + {31'd0, item.value[16]};
        case (hbc_pkg::op_t'(item.op))
            hbc_pkg::OP_H2S: res.result = hbc_pkg::half_to_single(item.value[15:0]);
            hbc_pkg::OP_S2H: res.result = {16'd0, hbc_pkg::single_to_half(item.value)};
            hbc_pkg::OP_B2S: res.result = {item.value[15:0], 16'd0};
            hbc_pkg::OP_S2B: res.result = {16'd0, s2b[31:16]};
            default:         res.result = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// ----- sv/half_and_bfloat_converter.sv -----
// channel  dir  payload
// in       in   op[1:0], value[31:0]
// out      out  result[31:0]
// The result register is loaded from the input register through the converter;
// one transfer per cycle while the sink does not stall. The input register is the
// only conversion stage; the result register holds while the sink stalls, and the
// input side accepts whenever it can advance. Reset clears both valid flags.
`default_nettype none
module half_and_bfloat_converter (
    input wire clk,
    input wire rst_n,
    hbc_stream_if.sink   in,
    hbc_stream_if.source out
);
    hbc_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    hbc_pkg::out_item_t conv;
    hbc_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    logic               adv;

    assign adv = !out_valid_reg || out.ready;
    assign in.ready = !in_valid_reg || adv;
    assign out.valid = out_valid_reg;
    assign out.data = out_reg.result;

    hbc_convert u_conv (
        .item (in_reg),
        .res  (conv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                out_valid_reg <= in_valid_reg;
            if (in.ready)
                in_valid_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid_reg)
            out_reg <= conv;
        if (in.ready && in.valid)
        begin
            in_reg.op    <= in.data[33:32];
            in_reg.value <= in.data[31:0];
        end
    end
endmodule
`default_nettype wire

// ----- sv/hbc_checker.sv -----
`default_nettype none
module hbc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [31:0] out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready |=> out_valid)
        else $error("result missing after transfer");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && in_ready && (!out_valid || out_ready) ##1
        (!in_valid || !in_ready) && (!out_valid || out_ready) |=> !out_valid)
        else $error("result invented");
endmodule

bind half_and_bfloat_converter hbc_checker u_hbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_data  (out.data)
);
`default_nettype wire

// ----- dv/half_and_bfloat_converter_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module half_and_bfloat_converter_tb;

    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;

    hbc_stream_if #(.W(34)) in_ch ();
    hbc_stream_if #(.W(32)) out_ch ();

    half_and_bfloat_converter dut (
        .clk(clk),
        .rst_n(rst_n),
        .in(in_ch.sink),
        .out(out_ch.source)
    );

    logic [31:0] expected_results[$];
    int          mismatch_count;
    int          checked_count;
    int          sent_count;
    int          idle_cycles;
    bit          allow_gaps;
    int          op_counts[4];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] convert_half_to_single(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  ex;
        logic [10:0] frac;
        logic [7:0]  n;
        sign = {h[15], 31'd0};
        ex = h[14:10];
        frac = {1'b0, h[9:0]};
        n = 8'd0;
        if (ex == 5'h1F)
            return sign | 32'h7F80_0000 | {9'd0, frac[9:0], 13'd0};
        if (ex == 5'd0)
        begin
            if (frac == 11'd0)
                return sign;
            while (!frac[10])
            begin
                frac = frac << 1;
                n = n + 8'd1;
            end
            return sign | {1'b0, 8'(8'd113 - n), frac[9:0], 13'd0};
        end
        return sign | {1'b0, 8'({3'd0, ex} + 8'd112), frac[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] convert_single_to_half(input logic [31:0] f);
        logic [15:0] sign;
        int          ex;
        int          sh;
        logic [23:0] frac;
        sign = {f[31], 15'd0};
        ex = int'(f[30:23]) - 127;
        frac = {1'b0, f[22:0]};
        if (ex >= 16)
            return {16'd0, sign | 16'h7C00};
        if (ex <= -15)
        begin
            sh = -14 - ex;
            if (sh > 24)
                sh = 24;
            frac = frac | 24'h80_0000;
            frac = frac >> sh;
            frac = frac + 24'h1000;
            return {16'd0, sign | {5'd0, frac[23:13]}};
        end
        frac = frac + 24'h1000;
        if (frac[23])
        begin
            frac = 24'd0;
            ex = ex + 1;
        end
        return {16'd0, sign | {1'b0, 5'(ex + 15), frac[22:13]}};
    endfunction

    function automatic logic [31:0] convert_single_to_bfloat(input logic [31:0] f);
        logic [31:0] s;
        s = f + 32'h7FFF + {31'd0, f[16]};
        return {16'd0, s[31:16]};
    endfunction

    function automatic logic [31:0] predict_conversion(input hbc_pkg::op_t op,
                                                       input logic [31:0] v);
        case (op)
            hbc_pkg::OP_H2S: return convert_half_to_single(v[15:0]);
            hbc_pkg::OP_S2H: return convert_single_to_half(v);
            hbc_pkg::OP_B2S: return {v[15:0], 16'd0};
            default: return convert_single_to_bfloat(v);
        endcase
    endfunction

    task automatic send_conversion(input hbc_pkg::op_t op, input logic [31:0] v);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {op, v};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_conversion(op, v));
        op_counts[op] = op_counts[op] + 1;
        sent_count = sent_count + 1;
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_results();
        go_idle();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] random_single();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'($urandom_range(89, 142));
            1: v[30:23] = 8'($urandom_range(100, 115));
            2: v[30:23] = 8'($urandom_range(140, 143));
            3: v[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_half_to_single();
        send_conversion(hbc_pkg::OP_H2S, 32'h0000_0000);
        send_conversion(hbc_pkg::OP_H2S, 32'hFFFF_8000);
        send_conversion(hbc_pkg::OP_H2S, 32'h0000_0001);
        send_conversion(hbc_pkg::OP_H2S, 32'h0000_83FF);
        send_conversion(hbc_pkg::OP_H2S, 32'h0000_7C00);
        send_conversion(hbc_pkg::OP_H2S, 32'hABCD_FFFF);
        send_conversion(hbc_pkg::OP_H2S, 32'h0000_3C00);
    endtask

    task automatic test_single_to_half();
        send_conversion(hbc_pkg::OP_S2H, 32'h7FC0_0000);
        send_conversion(hbc_pkg::OP_S2H, 32'hFF80_0000);
        send_conversion(hbc_pkg::OP_S2H, 32'h477F_F000);
        send_conversion(hbc_pkg::OP_S2H, 32'h387F_F000);
        send_conversion(hbc_pkg::OP_S2H, 32'h8000_0001);
        send_conversion(hbc_pkg::OP_S2H, 32'h3300_0000);
        send_conversion(hbc_pkg::OP_S2H, 32'h3F80_0FFF);
        send_conversion(hbc_pkg::OP_S2H, 32'h4780_0000);
    endtask

    task automatic test_bfloat_paths();
        send_conversion(hbc_pkg::OP_B2S, 32'hFFFF_0000);
        send_conversion(hbc_pkg::OP_B2S, 32'h0000_FFFF);
        send_conversion(hbc_pkg::OP_S2B, 32'hFFFF_FFFF);
        send_conversion(hbc_pkg::OP_S2B, 32'h3F80_8000);
        send_conversion(hbc_pkg::OP_S2B, 32'h3F81_8000);
        send_conversion(hbc_pkg::OP_S2B, 32'h0000_0000);
        send_conversion(hbc_pkg::OP_S2B, 32'h7F7F_FFFF);
    endtask

    task automatic test_random_mix(input int count);
        hbc_pkg::op_t op;
        logic [31:0]  v;
        for (int i = 0; i < count; i++)
        begin
            op = hbc_pkg::op_t'($urandom_range(0, 3));
            v = (op == hbc_pkg::OP_S2H || op == hbc_pkg::OP_S2B) ?
                random_single() : $urandom();
            send_conversion(op, v);
        end
    endtask

    task automatic test_sender_pause();
        drain_results();
        test_random_mix(20);
        drain_results();
    endtask

    initial
    begin : result_checker
        logic [31:0] want;
        int          stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (allow_gaps && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 8);
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            if (out_ch.valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, out_ch.data);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_count = checked_count + 1;
                    if (out_ch.data !== want)
                    begin
                        $display("%0t: result mismatch, expected %h actual %h",
                                 $time, want, out_ch.data);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        mismatch_count = 0;
        checked_count = 0;
        sent_count = 0;
        allow_gaps = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_half_to_single();
        test_single_to_half();
        test_bfloat_paths();
        test_random_mix(300);
        test_sender_pause();
        test_random_mix(200);
        allow_gaps = 1'b0;
        test_random_mix(160);
        drain_results();
        repeat (10) @(negedge clk);
        $display("Sent %0d conversions (h2s %0d, s2h %0d, b2s %0d, s2b %0d); checked %0d.",
                 sent_count, op_counts[0], op_counts[1], op_counts[2], op_counts[3],
                 checked_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/hbc_pkg.sv
sv/hbc_stream_if.sv
sv/hbc_convert.sv
sv/half_and_bfloat_converter.sv
sv/hbc_checker.sv
dv/half_and_bfloat_converter_tb.sv
